### src/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Types and constants shared by the 24-bit bitmap stream decoder modules.
// ----------------------------------------------------------------------------
package bmpd_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_SIGNATURE = 3'd0,
		ERR_SHORT_HDR = 3'd1,
		ERR_FORMAT    = 3'd2,
		ERR_TOO_LARGE = 3'd3,
		ERR_OFFSET    = 3'd4
	} err_t;

	// header byte positions at which a field is complete
	localparam logic [31:0] POS_SIGNATURE = 32'd1;
	localparam logic [31:0] POS_OFFSET    = 32'd13;
	localparam logic [31:0] POS_INFO_SIZE = 32'd17;
	localparam logic [31:0] POS_WIDTH     = 32'd21;
	localparam logic [31:0] POS_HEIGHT    = 32'd25;
	localparam logic [31:0] POS_PLANES    = 32'd27;
	localparam logic [31:0] POS_DEPTH     = 32'd29;
	localparam logic [31:0] POS_COMPRESS  = 32'd33;

	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
	localparam logic [15:0] BMP_PLANES    = 16'd1;
	localparam logic [15:0] BMP_DEPTH     = 16'd24;
	localparam logic [32:0] FILE_HDR_SIZE = 33'd14;
	localparam logic [7:0]  KEY_LEVEL     = 8'd255;
	localparam logic [7:0]  ALPHA_CLEAR   = 8'h00;
	localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

	// depth of the queue between parser and formatter
	localparam int QUEUE_DEPTH = 4;

	// one input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_t;

	// one result word
	typedef struct packed {
		kind_t       kind;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [11:0] column;
		logic [11:0] row;
		logic [31:0] rgba;
		logic        last_pixel;
		err_t        error_code;
	} out_t;

	// parsed event handed from parser to formatter
	typedef struct packed {
		kind_t       kind;
		logic [12:0] dim_w;
		logic [12:0] dim_h;
		logic [11:0] column;
		logic [11:0] srow;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        last;
		err_t        code;
	} ev_t;

endpackage

### src/bmpd_front.sv
// ----------------------------------------------------------------------------
// bmpd_front
// Byte parser: walks the header, skips to the pixel data, gathers B,G,R
// triples and skips row padding. Produces at most one event per byte.
// ----------------------------------------------------------------------------
module bmpd_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bmpd_pkg::in_t  data,
	input  logic           accept,
	output bmpd_pkg::ev_t  ev,
	output logic           ev_push
);
	import bmpd_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_SKIP   = 5'b00010,
		PH_PIXEL  = 5'b00100,
		PH_PAD    = 5'b01000,
		PH_IDLE   = 5'b10000
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [31:0]     pos_q, pos_d;
	logic [31:0]     acc_q, acc_d;
	logic [31:0]     pix_off_q, pix_off_d;
	logic [31:0]     info_q, info_d;
	logic [WW-1:0]   width_q, width_d;
	logic [HW-1:0]   height_q, height_d;
	logic            fmt_bad_q, fmt_bad_d;
	logic            too_big_q, too_big_d;
	logic [WW-1:0]   col_q, col_d;
	logic [HW-1:0]   srow_q, srow_d;
	logic [1:0]      bip_q, bip_d;
	logic [7:0]      blue_q, blue_d;
	logic [7:0]      green_q, green_d;
	logic [1:0]      pad_q, pad_d;

	// parse one byte against the state, restarted when file_start is set
	always_comb begin
		logic [7:0]    b;
		logic [15:0]   lo16;
		logic          take_pixel;
		logic          last;
		logic [WW:0]   col_inc;
		logic [HW:0]   srow_inc;
		logic [31:0]   w32;
		logic [31:0]   h32;
		logic [31:0]   c32;
		logic [31:0]   r32;

		b = data.data_byte;
		if (data.file_start) begin
			phase_d   = PH_HEADER;
			pos_d     = '0;
			acc_d     = '0;
			pix_off_d = '0;
			info_d    = '0;
			width_d   = '0;
			height_d  = '0;
			fmt_bad_d = 1'b0;
			too_big_d = 1'b0;
			col_d     = '0;
			srow_d    = '0;
			bip_d     = '0;
			blue_d    = '0;
			green_d   = '0;
			pad_d     = '0;
		end else begin
			phase_d   = phase_q;
			pos_d     = pos_q;
			acc_d     = acc_q;
			pix_off_d = pix_off_q;
			info_d    = info_q;
			width_d   = width_q;
			height_d  = height_q;
			fmt_bad_d = fmt_bad_q;
			too_big_d = too_big_q;
			col_d     = col_q;
			srow_d    = srow_q;
			bip_d     = bip_q;
			blue_d    = blue_q;
			green_d   = green_q;
			pad_d     = pad_q;
		end

		ev         = '0;
		ev_push    = 1'b0;
		take_pixel = 1'b0;
		lo16       = '0;
		last       = 1'b0;
		col_inc    = '0;
		srow_inc   = '0;
		w32        = '0;
		h32        = '0;
		c32        = '0;
		r32        = '0;

		case (phase_d)
			PH_HEADER: begin
				acc_d = {b, acc_d[31:8]};
				lo16  = acc_d[31:16];
				if (pos_d == POS_SIGNATURE) begin
					if (lo16 != BMP_SIGNATURE) begin
						ev_push = 1'b1;
						ev.kind = KIND_ERROR;
						ev.code = ERR_SIGNATURE;
						phase_d = PH_IDLE;
					end
				end else if (pos_d == POS_OFFSET) begin
					pix_off_d = acc_d;
				end else if (pos_d == POS_INFO_SIZE) begin
					info_d = acc_d;
					if (acc_d < MIN_INFO_SIZE) begin
						ev_push = 1'b1;
						ev.kind = KIND_ERROR;
						ev.code = ERR_SHORT_HDR;
						phase_d = PH_IDLE;
					end
				end else if (pos_d == POS_WIDTH) begin
					width_d = acc_d[WW-1:0];
					if (acc_d == '0) fmt_bad_d = 1'b1;
					if (acc_d > 32'(MAX_WIDTH)) too_big_d = 1'b1;
				end else if (pos_d == POS_HEIGHT) begin
					height_d = acc_d[HW-1:0];
					if (acc_d == '0) fmt_bad_d = 1'b1;
					if (acc_d > 32'(MAX_HEIGHT)) too_big_d = 1'b1;
				end else if (pos_d == POS_PLANES) begin
					if (lo16 != BMP_PLANES) fmt_bad_d = 1'b1;
				end else if (pos_d == POS_DEPTH) begin
					if (lo16 != BMP_DEPTH) fmt_bad_d = 1'b1;
				end else if (pos_d == POS_COMPRESS) begin
					ev_push = 1'b1;
					if (acc_d != '0 || fmt_bad_d) begin
						ev.kind = KIND_ERROR;
						ev.code = ERR_FORMAT;
						phase_d = PH_IDLE;
					end else if (too_big_d) begin
						ev.kind = KIND_ERROR;
						ev.code = ERR_TOO_LARGE;
						phase_d = PH_IDLE;
					end else if ({1'b0, pix_off_d} < FILE_HDR_SIZE + {1'b0, info_d}) begin
						ev.kind = KIND_ERROR;
						ev.code = ERR_OFFSET;
						phase_d = PH_IDLE;
					end else begin
						w32      = 32'(width_d);
						h32      = 32'(height_d);
						ev.kind  = KIND_HEADER;
						ev.dim_w = w32[12:0];
						ev.dim_h = h32[12:0];
						phase_d  = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (pos_d == pix_off_d) begin
					phase_d    = PH_PIXEL;
					take_pixel = 1'b1;
				end
			end
			PH_PIXEL: begin
				take_pixel = 1'b1;
			end
			PH_PAD: begin
				pad_d = pad_d - 2'd1;
				if (pad_d == '0) begin
					srow_d  = srow_d + 1'b1;
					phase_d = PH_PIXEL;
				end
			end
			default: begin
			end
		endcase

		// gather one pixel byte; the red byte completes the pixel
		if (take_pixel) begin
			case (bip_d)
				2'd0: begin
					blue_d = b;
					bip_d  = 2'd1;
				end
				2'd1: begin
					green_d = b;
					bip_d   = 2'd2;
				end
				default: begin
					bip_d    = 2'd0;
					col_inc  = {1'b0, col_d} + 1'b1;
					srow_inc = {1'b0, srow_d} + 1'b1;
					last     = (col_inc == {1'b0, width_d}) &&
						(srow_inc == {1'b0, height_d});
					c32      = 32'(col_d);
					r32      = 32'(srow_d);
					h32      = 32'(height_d);
					w32      = 32'(width_d);
					ev_push  = 1'b1;
					ev.kind  = KIND_PIXEL;
					ev.column = c32[11:0];
					ev.srow  = r32[11:0];
					ev.dim_h = h32[12:0];
					ev.blue  = blue_d;
					ev.green = green_d;
					ev.red   = b;
					ev.last  = last;
					col_d    = col_inc[WW-1:0];
					if (last) begin
						phase_d = PH_IDLE;
					end else if (col_inc == {1'b0, width_d}) begin
						col_d = '0;
						pad_d = w32[1:0];
						if (w32[1:0] == 2'd0) begin
							srow_d = srow_inc[HW-1:0];
						end else begin
							phase_d = PH_PAD;
						end
					end
				end
			endcase
		end

		pos_d = pos_d + 32'd1;
		ev_push = ev_push && accept;
	end

	// advance control state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			acc_q     <= '0;
			pix_off_q <= '0;
			info_q    <= '0;
			width_q   <= '0;
			height_q  <= '0;
			fmt_bad_q <= 1'b0;
			too_big_q <= 1'b0;
			col_q     <= '0;
			srow_q    <= '0;
			bip_q     <= '0;
			pad_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			acc_q     <= acc_d;
			pix_off_q <= pix_off_d;
			info_q    <= info_d;
			width_q   <= width_d;
			height_q  <= height_d;
			fmt_bad_q <= fmt_bad_d;
			too_big_q <= too_big_d;
			col_q     <= col_d;
			srow_q    <= srow_d;
			bip_q     <= bip_d;
			pad_q     <= pad_d;
		end
	end

	// hold color bytes of the pixel in progress
	always_ff @(posedge clk) begin
		if (accept) begin
			blue_q  <= blue_d;
			green_q <= green_d;
		end
	end

endmodule

### src/bmpd_queue.sv
// ----------------------------------------------------------------------------
// bmpd_queue
// Small event queue between the parser and the result formatter.
// ----------------------------------------------------------------------------
module bmpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  bmpd_pkg::ev_t wr_ev,
	input  logic          push,
	output logic          full,
	output bmpd_pkg::ev_t rd_ev,
	output logic          not_empty,
	input  logic          pop
);
	import bmpd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	ev_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == (PW + 1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_ev     = mem_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_ev;
	end

endmodule

### src/bmpd_back.sv
// ----------------------------------------------------------------------------
// bmpd_back
// Result formatter: turns parsed events into result words (top-down row,
// RGBA with color key) and holds them in the output register.
// ----------------------------------------------------------------------------
module bmpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bmpd_pkg::ev_t  ev,
	input  logic           ev_valid,
	output logic           ev_pop,
	output bmpd_pkg::out_t res,
	output logic           res_valid,
	input  logic           res_stall
);
	import bmpd_pkg::*;

	out_t res_q;
	out_t fmt;
	logic res_valid_q;

	// format one event; fields not used by the kind stay zero
	always_comb begin
		logic [7:0] alpha;
		alpha = (ev.red == KEY_LEVEL && ev.blue == KEY_LEVEL) ? ALPHA_CLEAR : ALPHA_OPAQUE;
		fmt = '0;
		fmt.kind = ev.kind;
		case (ev.kind)
			KIND_HEADER: begin
				fmt.image_width  = ev.dim_w;
				fmt.image_height = ev.dim_h;
			end
			KIND_PIXEL: begin
				fmt.column     = ev.column;
				fmt.row        = ev.dim_h[11:0] - 12'd1 - ev.srow;
				fmt.rgba       = {ev.red, ev.green, ev.blue, alpha};
				fmt.last_pixel = ev.last;
			end
			default: begin
				fmt.error_code = ev.code;
			end
		endcase
	end

	assign ev_pop    = ev_valid && (!res_valid_q || !res_stall);
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// load output register when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ev_pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop) res_q <= fmt;
	end

endmodule

### src/bmp_24bit_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp_24bit_stream_decoder
// Streaming decoder for 24-bit uncompressed bitmap files, one byte per word.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while byte_stall is low and gives at
// most one result word per byte: a header word once the header is checked, one
// pixel word per B,G,R triple (RGBA, top-down row, alpha cleared where red and
// blue are both 255), or one error word, after which bytes are dropped until
// the next file_start. Each byte is parsed in the cycle it is accepted; results
// pass through a four-entry queue and then an output register, and byte_stall
// follows the queue's full flag, which is reached only when the result side
// stalls.
module bmp_24bit_stream_decoder #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bmpd_pkg::in_t  byte_data,
	input  logic           byte_valid,
	output logic           byte_stall,
	output bmpd_pkg::out_t res_data,
	output logic           res_valid,
	input  logic           res_stall
);
	import bmpd_pkg::*;

	ev_t  push_ev;
	ev_t  head_ev;
	logic push;
	logic full;
	logic not_empty;
	logic pop;
	logic accept;

	// stall the byte side while the queue is full
	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	bmpd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.data    (byte_data),
		.accept  (accept),
		.ev      (push_ev),
		.ev_push (push)
	);

	bmpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_ev     (push_ev),
		.push      (push),
		.full      (full),
		.rd_ev     (head_ev),
		.not_empty (not_empty),
		.pop       (pop)
	);

	bmpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (head_ev),
		.ev_valid  (not_empty),
		.ev_pop    (pop),
		.res       (res_data),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

### tb/bmp_24bit_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// bmp_24bit_stream_decoder_test
// Self-checking bench for the 24-bit bitmap stream decoder. Whole files are
// fed one byte word at a time: directed files hit each header error code, the
// check priorities and the size limits. Random files follow, mostly well
// formed with some broken fields, truncations and loose noise, and cover row
// padding and the color key. A bit-level predictor keeps its own parser
// state, and every result word is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module bmp_24bit_stream_decoder_test;
	import bmpd_pkg::*;

	localparam int MAX_W           = 4096;
	localparam int MAX_H           = 4096;
	localparam int CYCLE_LIMIT     = 40000;
	localparam int END_CYCLES      = 16;
	localparam int RANDOM_BYTES    = 160;
	localparam int HEADER_FILL_MAX = 160;
	localparam logic [31:0] STD_INFO   = MIN_INFO_SIZE;
	localparam logic [31:0] STD_OFFSET = 32'd54;

	// bytes needed to reach each header check
	localparam int SIG_BYTES  = int'(POS_SIGNATURE) + 1;
	localparam int INFO_BYTES = int'(POS_INFO_SIZE) + 1;
	localparam int HDR_BYTES  = int'(POS_COMPRESS) + 1;

	// parser phases of the predictor
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_PAD,
		PH_DONE
	} parse_phase_t;

	// header field broken in a random file
	typedef enum logic [2:0] {
		FLAW_SIGNATURE,
		FLAW_INFO_SIZE,
		FLAW_WIDTH,
		FLAW_HEIGHT,
		FLAW_PLANES,
		FLAW_DEPTH,
		FLAW_COMPRESS,
		FLAW_OFFSET
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_t  byte_data = '0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	out_t res_data;
	logic res_valid;
	logic res_stall = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int bytes_sent = 0;

	out_t pending_results[$];
	out_t oldest_result;
	logic [7:0] file_bytes[$];

	// predictor state
	parse_phase_t prs_phase;
	logic [31:0] file_pos;
	logic [31:0] field_acc;
	logic [31:0] data_offset;
	logic [31:0] hdr_size;
	logic [31:0] img_w;
	logic [31:0] img_h;
	bit          fmt_bad;
	bit          too_big;
	logic [31:0] pix_col;
	logic [31:0] pix_srow;
	logic [1:0]  chan_idx;
	logic [7:0]  blue_q;
	logic [7:0]  green_q;
	logic [1:0]  pad_left;

	bmp_24bit_stream_decoder #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_data(byte_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.res_data(res_data),
		.res_valid(res_valid),
		.res_stall(res_stall)
	);

	always #5 clk = ~clk;

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("bmp_24bit_stream_decoder_test NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	// stall the result side at random and compare each accepted result word
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none expected, kind", res_data.kind, 0);
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("kind", res_data.kind, oldest_result.kind);
				check_field("image_width", res_data.image_width, oldest_result.image_width);
				check_field("image_height", res_data.image_height,
					oldest_result.image_height);
				check_field("column", res_data.column, oldest_result.column);
				check_field("row", res_data.row, oldest_result.row);
				check_field("rgba", res_data.rgba, oldest_result.rgba);
				check_field("last_pixel", res_data.last_pixel, oldest_result.last_pixel);
				check_field("error_code", res_data.error_code, oldest_result.error_code);
			end
		end
	end

	function automatic void clear_parser();
		prs_phase = PH_HEADER;
		file_pos = '0;
		field_acc = '0;
		data_offset = '0;
		hdr_size = '0;
		img_w = '0;
		img_h = '0;
		fmt_bad = 1'b0;
		too_big = 1'b0;
		pix_col = '0;
		pix_srow = '0;
		chan_idx = '0;
		blue_q = '0;
		green_q = '0;
		pad_left = '0;
	endfunction

	// advance the parser by one byte; return 1 with the result it causes
	function automatic bit decode_byte(input in_t w, output out_t r);
		bit          hit;
		bit          raise;
		bit          last;
		err_t        code;
		logic [7:0]  alpha;
		logic [31:0] flipped;
		r = '0;
		hit = 1'b0;
		raise = 1'b0;
		code = ERR_SIGNATURE;
		if (w.file_start)
			clear_parser();
		// enter pixel data once the offset is reached
		if (prs_phase == PH_SKIP && file_pos == data_offset)
			prs_phase = PH_PIXEL;
		case (prs_phase)
			PH_HEADER: begin
				field_acc = {w.data_byte, field_acc[31:8]};
				case (file_pos)
					POS_SIGNATURE: begin
						if (field_acc[31:16] != BMP_SIGNATURE) begin
							raise = 1'b1;
							code = ERR_SIGNATURE;
						end
					end
					POS_OFFSET: data_offset = field_acc;
					POS_INFO_SIZE: begin
						hdr_size = field_acc;
						if (hdr_size < MIN_INFO_SIZE) begin
							raise = 1'b1;
							code = ERR_SHORT_HDR;
						end
					end
					POS_WIDTH: begin
						img_w = field_acc;
						if (img_w == 0)
							fmt_bad = 1'b1;
						if (img_w > MAX_W)
							too_big = 1'b1;
					end
					POS_HEIGHT: begin
						img_h = field_acc;
						if (img_h == 0)
							fmt_bad = 1'b1;
						if (img_h > MAX_H)
							too_big = 1'b1;
					end
					POS_PLANES: begin
						if (field_acc[31:16] != BMP_PLANES)
							fmt_bad = 1'b1;
					end
					POS_DEPTH: begin
						if (field_acc[31:16] != BMP_DEPTH)
							fmt_bad = 1'b1;
					end
					POS_COMPRESS: begin
						if (field_acc != 0)
							fmt_bad = 1'b1;
						// format beats size, size beats offset
						raise = 1'b1;
						if (fmt_bad) begin
							code = ERR_FORMAT;
						end else if (too_big) begin
							code = ERR_TOO_LARGE;
						end else if ({1'b0, data_offset} < FILE_HDR_SIZE + {1'b0, hdr_size}) begin
							code = ERR_OFFSET;
						end else begin
							raise = 1'b0;
							r.kind = KIND_HEADER;
							r.image_width = img_w[12:0];
							r.image_height = img_h[12:0];
							prs_phase = PH_SKIP;
							hit = 1'b1;
						end
					end
					default: ;
				endcase
			end
			PH_PIXEL: begin
				case (chan_idx)
					2'd0: begin
						blue_q = w.data_byte;
						chan_idx = 2'd1;
					end
					2'd1: begin
						green_q = w.data_byte;
						chan_idx = 2'd2;
					end
					default: begin
						chan_idx = 2'd0;
						alpha = (w.data_byte == KEY_LEVEL && blue_q == KEY_LEVEL) ?
							ALPHA_CLEAR : ALPHA_OPAQUE;
						last = (pix_col + 32'd1 == img_w) && (pix_srow + 32'd1 == img_h);
						flipped = img_h - 32'd1 - pix_srow;
						r.kind = KIND_PIXEL;
						r.column = pix_col[11:0];
						r.row = flipped[11:0];
						r.rgba = {w.data_byte, green_q, blue_q, alpha};
						r.last_pixel = last;
						hit = 1'b1;
						pix_col = pix_col + 32'd1;
						// wrap the column at the end of a stored row
						if (last) begin
							prs_phase = PH_DONE;
						end else if (pix_col >= img_w) begin
							pix_col = '0;
							pad_left = img_w[1:0];
							if (pad_left == 0)
								pix_srow = pix_srow + 32'd1;
							else
								prs_phase = PH_PAD;
						end
					end
				endcase
			end
			PH_PAD: begin
				pad_left = pad_left - 2'd1;
				if (pad_left == 0) begin
					pix_srow = pix_srow + 32'd1;
					prs_phase = PH_PIXEL;
				end
			end
			default: ;
		endcase
		if (raise) begin
			r.kind = KIND_ERROR;
			r.error_code = code;
			prs_phase = PH_DONE;
			hit = 1'b1;
		end
		file_pos = file_pos + 32'd1;
		return hit;
	endfunction

	// drive one byte word, idling first at random, and hold it until taken
	task automatic send_byte(input logic [7:0] value, input logic start);
		in_t  w;
		out_t r;
		w.data_byte = value;
		w.file_start = start;
		if ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		byte_data <= w;
		byte_valid <= 1'b1;
		do
			@(posedge clk);
		while (byte_stall);
		if (decode_byte(w, r))
			pending_results.push_back(r);
		bytes_sent++;
	endtask

	// hold off the sender until every predicted result has come out
	task automatic wait_results_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_le(input logic [31:0] value, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			file_bytes.push_back(value[8*i +: 8]);
	endtask

	// start a new file image with the given header fields
	task automatic build_header(input logic [15:0] sig, input logic [31:0] off,
			input logic [31:0] isz, input logic [31:0] wd, input logic [31:0] ht,
			input logic [15:0] planes, input logic [15:0] depth,
			input logic [31:0] comp);
		file_bytes.delete();
		put_le(sig, 2);
		put_le($urandom, 4);
		put_le($urandom, 4);
		put_le(off, 4);
		put_le(isz, 4);
		put_le(wd, 4);
		put_le(ht, 4);
		put_le(planes, 2);
		put_le(depth, 2);
		put_le(comp, 4);
		// fill the rest of the header up to the pixel offset
		while (file_bytes.size() < off && file_bytes.size() < HEADER_FILL_MAX)
			file_bytes.push_back($urandom_range(255));
	endtask

	// append stored rows with padding, then a few stray bytes past the end
	task automatic add_pixels(input int wd, input int ht);
		logic [7:0] v;
		for (int y = 0; y < ht; y++) begin
			for (int x = 0; x < wd * 3; x++) begin
				// favor the channel extremes so the color key shows up often
				if ($urandom_range(2) == 0)
					v = KEY_LEVEL;
				else if ($urandom_range(3) == 0)
					v = 8'h00;
				else
					v = $urandom_range(255);
				file_bytes.push_back(v);
			end
			for (int k = 0; k < wd % 4; k++)
				file_bytes.push_back($urandom_range(255));
		end
		repeat ($urandom_range(2))
			file_bytes.push_back($urandom_range(255));
	endtask

	task automatic send_file(input logic first_flag);
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], (i == 0) && first_flag);
	endtask

	// send a header cut right after the byte that decides it
	task automatic send_header_only(input int nbytes, input logic [15:0] sig,
			input logic [31:0] off, input logic [31:0] isz, input logic [31:0] wd,
			input logic [31:0] ht, input logic [15:0] planes, input logic [15:0] depth,
			input logic [31:0] comp);
		build_header(sig, off, isz, wd, ht, planes, depth, comp);
		while (file_bytes.size() > nbytes)
			void'(file_bytes.pop_back());
		send_file(1'b1);
	endtask

	// a file right after reset, with no start flag on its first byte
	task automatic test_no_file_start();
		build_header(BMP_SIGNATURE, STD_OFFSET, STD_INFO, 1, 1, BMP_PLANES, BMP_DEPTH, 0);
		file_bytes.push_back(KEY_LEVEL);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(KEY_LEVEL);
		file_bytes.push_back(8'h00);
		send_file(1'b0);
		wait_results_drained();
	endtask

	task automatic test_bad_signature();
		send_header_only(SIG_BYTES, {BMP_SIGNATURE[7:0], BMP_SIGNATURE[15:8]},
			STD_OFFSET, STD_INFO, 1, 1, BMP_PLANES, BMP_DEPTH, 0);
		wait_results_drained();
	endtask

	task automatic test_short_header();
		send_header_only(INFO_BYTES, BMP_SIGNATURE, STD_OFFSET, MIN_INFO_SIZE - 1, 1, 1,
			BMP_PLANES, BMP_DEPTH, 0);
		wait_results_drained();
	endtask

	task automatic test_format_checks();
		// format wins over size and offset
		send_header_only(HDR_BYTES, BMP_SIGNATURE, 32'd0, STD_INFO, 0, 5000, BMP_PLANES,
			BMP_DEPTH, 0);
		send_header_only(HDR_BYTES, BMP_SIGNATURE, STD_OFFSET, STD_INFO, 1, 1, BMP_PLANES,
			BMP_DEPTH, 32'h8000_0000);
		wait_results_drained();
	endtask

	task automatic test_too_large();
		// size wins over offset
		send_header_only(HDR_BYTES, BMP_SIGNATURE, 32'd0, STD_INFO, MAX_W + 1, 1,
			BMP_PLANES, BMP_DEPTH, 0);
		// negative height reads as huge
		send_header_only(HDR_BYTES, BMP_SIGNATURE, STD_OFFSET, STD_INFO, 1, 32'hFFFF_FFFF,
			BMP_PLANES, BMP_DEPTH, 0);
		wait_results_drained();
	endtask

	task automatic test_offset_in_header();
		send_header_only(HDR_BYTES, BMP_SIGNATURE, STD_OFFSET - 1, STD_INFO, 1, 1,
			BMP_PLANES, BMP_DEPTH, 0);
		send_header_only(HDR_BYTES, BMP_SIGNATURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
			BMP_PLANES, BMP_DEPTH, 0);
		wait_results_drained();
	endtask

	task automatic test_max_size();
		// full-size header and a couple of pixels, then cut short
		build_header(BMP_SIGNATURE, STD_OFFSET, STD_INFO, MAX_W, MAX_H, BMP_PLANES,
			BMP_DEPTH, 0);
		repeat (7)
			file_bytes.push_back($urandom_range(255));
		send_file(1'b1);
		wait_results_drained();
	endtask

	// mostly good files with random content, some broken, cut short or noise
	task automatic gen_random_file();
		int          pick;
		int          wd;
		int          ht;
		int          cut;
		logic [31:0] isz;
		logic [31:0] off;
		logic [31:0] wv;
		logic [31:0] hv;
		logic [31:0] comp;
		logic [15:0] sig;
		logic [15:0] planes;
		logic [15:0] depth;
		pick = $urandom_range(99);
		if (pick >= 90) begin
			// loose bytes with an occasional restart among them
			repeat ($urandom_range(1, 40))
				send_byte($urandom_range(255), $urandom_range(7) == 0);
		end else begin
			wd = $urandom_range(1, 5);
			ht = $urandom_range(1, 3);
			isz = STD_INFO + $urandom_range(0, 3);
			off = 32'd14 + isz + $urandom_range(0, 3);
			sig = BMP_SIGNATURE;
			planes = BMP_PLANES;
			depth = BMP_DEPTH;
			comp = '0;
			wv = wd;
			hv = ht;
			if (pick >= 70) begin
				case (flaw_t'($urandom_range(0, 7)))
					FLAW_SIGNATURE: sig = $urandom;
					FLAW_INFO_SIZE: isz = $urandom_range(0, 39);
					FLAW_WIDTH: wv = $urandom_range(1) ? 32'd0 : $urandom;
					FLAW_HEIGHT: hv = $urandom_range(1) ? 32'd0 : $urandom;
					FLAW_PLANES: planes = $urandom_range(0, 3);
					FLAW_DEPTH: depth = $urandom_range(255);
					FLAW_COMPRESS: comp = $urandom_range(0, 3);
					default: off = $urandom_range(0, 14 + isz);
				endcase
			end
			build_header(sig, off, isz, wv, hv, planes, depth, comp);
			add_pixels(wd, ht);
			// cut now and then so the next file restarts the parser midway
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(1, file_bytes.size());
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
			send_file(1'b1);
		end
	endtask

	// sender idle percentage for each random phase
	function automatic int phase_idle_pct(input int p);
		case (p)
			1: return 72;
			3: return 16;
			default: return 0;
		endcase
	endfunction

	// receiver stall percentage for each random phase
	function automatic int phase_stall_pct(input int p);
		case (p)
			2: return 72;
			3: return 16;
			default: return 0;
		endcase
	endfunction

	task automatic test_random_files();
		int target;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle_pct(p);
			recv_stall_pct = phase_stall_pct(p);
			target = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < target)
				gen_random_file();
			wait_results_drained();
		end
	endtask

	initial begin
		clear_parser();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		test_no_file_start();
		test_bad_signature();
		test_short_header();
		test_format_checks();
		test_too_large();
		test_offset_in_header();
		test_max_size();
		test_random_files();

		// let any late word show up
		wait_results_drained();
		repeat (END_CYCLES)
			@(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);

		if (mismatch_count == 0)
			$display("bmp_24bit_stream_decoder_test OK");
		else
			$display("bmp_24bit_stream_decoder_test NOT OK");
		$finish;
	end

endmodule
